@@ sv/lacs_pkg.sv @@
// shared types, constants and widths for the local alignment cell scorer
package lacs_pkg;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int VALUE_W  = 24;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int SIZE_W   = 11;
   localparam int SCORE_IN_W = 16;
   localparam int PEN_W    = 15;
   localparam int WT_W     = 8;
   localparam int SCORE_W  = SCORE_IN_W + WT_W;
   localparam int CAND_W   = VALUE_W + 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_DIAG = 2'd1,
      DIR_LEFT = 2'd2,
      DIR_UP   = 2'd3
   } dir_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_ROWS = 2'd0,
      CSR_NUM_COLS = 2'd1,
      CSR_WEIGHTED = 2'd2
   } csr_index_type;

   typedef struct packed {
      dir_type             dir;
      logic [VALUE_W-1:0]  value;
   } entry_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [PEN_W-1:0]          open_p;
      logic [PEN_W-1:0]          ext_p;
      logic [ROW_W-1:0]          row;
      logic [COL_W-1:0]          col;
      logic                      first_row;
      logic                      first_col;
      logic                      done;
   } cell_in_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      dir_type            dir;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic               done;
   } cell_out_type;

   typedef struct packed {
      logic load;
      logic advance;
   } stage_ctrl_type;

   typedef struct packed {
      logic [VALUE_W-1:0] cell_value;
      logic [1:0]         direction;
      logic [VALUE_W-1:0] best_value;
      logic [SIZE_W-1:0]  best_row;
      logic [SIZE_W-1:0]  best_col;
      logic               matrix_done;
   } result_type;

endpackage

@@ sv/lacs_req_if.sv @@
// cell request channel
interface lacs_req_if;
   import lacs_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [SCORE_IN_W-1:0] match_score;
   logic [PEN_W-1:0]             open_penalty;
   logic [PEN_W-1:0]             ext_penalty;
   logic [WT_W-1:0]              row_weight;
   logic [WT_W-1:0]              col_weight;

   modport source (output valid, match_score, open_penalty, ext_penalty, row_weight,
                   col_weight, input ready);
   modport sink (input valid, match_score, open_penalty, ext_penalty, row_weight,
                 col_weight, output ready);
endinterface

@@ sv/lacs_rsp_if.sv @@
// cell result channel
interface lacs_rsp_if;
   import lacs_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] cell_value;
   logic [1:0]         direction;
   logic [VALUE_W-1:0] best_value;
   logic [SIZE_W-1:0]  best_row;
   logic [SIZE_W-1:0]  best_col;
   logic               matrix_done;

   modport source (output valid, cell_value, direction, best_value, best_row, best_col,
                   matrix_done, input ready);
   modport sink (input valid, cell_value, direction, best_value, best_row, best_col,
                 matrix_done, output ready);
endinterface

@@ sv/lacs_row_store.sv @@
// previous row store: value and direction per column, clearing sweep after reset
module lacs_row_store (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [lacs_pkg::COL_W-1:0] rd_addr,
   input  logic                      wr_en,
   input  logic [lacs_pkg::COL_W-1:0] wr_addr,
   input  lacs_pkg::entry_type       wr_data,
   output lacs_pkg::entry_type       rd_data,
   output logic                      busy
);
   import lacs_pkg::*;

   entry_type        mem [MAX_COLS];
   entry_type        rd_data_ff;
   logic             clr_ff;
   logic             clr_in;
   logic [COL_W-1:0] clr_addr_ff;
   logic [COL_W-1:0] clr_addr_in;
   logic             we;
   logic [COL_W-1:0] wa;
   entry_type        wd;

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == COL_W'(MAX_COLS - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_comb begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
      if (clr_ff) begin
         we = 1'b1;
         wa = clr_addr_ff;
         wd = '0;
      end
   end

   // write-to-read forwarding when one column follows itself
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (we && (wa == rd_addr)) begin
            rd_data_ff <= wd;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
      if (we) begin
         mem[wa] <= wd;
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_ff;

endmodule

@@ sv/lacs_cell_calc.sv @@
// cell stage: candidates, maximum, direction, left and diagonal neighbours
module lacs_cell_calc (
   input  logic                       clock,
   input  logic                       reset,
   input  lacs_pkg::stage_ctrl_type   ctrl,
   input  lacs_pkg::cell_in_type      cell_in,
   input  lacs_pkg::entry_type        up_entry,
   output logic [lacs_pkg::COL_W-1:0] wr_addr,
   output lacs_pkg::entry_type        wr_data,
   output lacs_pkg::cell_out_type     cell_out
);
   import lacs_pkg::*;

   cell_in_type        s2_ff;
   cell_out_type       s3_ff;
   logic [VALUE_W-1:0] left_value_ff;
   dir_type            left_dir_ff;
   logic [VALUE_W-1:0] diag_value_ff;

   logic [VALUE_W-1:0]       up_v;
   dir_type                  up_d;
   logic [VALUE_W-1:0]       lf_v;
   dir_type                  lf_d;
   logic [VALUE_W-1:0]       dg_v;
   logic                     edge_cell;
   logic [PEN_W-1:0]         pen_up;
   logic [PEN_W-1:0]         pen_lf;
   logic signed [CAND_W-1:0] cand_dg;
   logic signed [CAND_W-1:0] cand_up;
   logic signed [CAND_W-1:0] cand_lf;
   logic signed [CAND_W-1:0] mx;
   dir_type                  dir;
   logic [VALUE_W-1:0]       val;

   always_comb begin
      up_v      = s2_ff.first_row ? '0 : up_entry.value;
      up_d      = s2_ff.first_row ? DIR_NONE : up_entry.dir;
      lf_v      = s2_ff.first_col ? '0 : left_value_ff;
      lf_d      = s2_ff.first_col ? DIR_NONE : left_dir_ff;
      dg_v      = s2_ff.first_col ? '0 : diag_value_ff;
      edge_cell = s2_ff.first_row || s2_ff.first_col;
      pen_up    = (!edge_cell && (up_d == DIR_UP)) ? s2_ff.ext_p : s2_ff.open_p;
      pen_lf    = (!edge_cell && (lf_d == DIR_LEFT)) ? s2_ff.ext_p : s2_ff.open_p;
      cand_dg   = $signed({2'b00, dg_v}) + CAND_W'(s2_ff.score);
      cand_up   = $signed({2'b00, up_v}) - $signed({{(CAND_W-PEN_W){1'b0}}, pen_up});
      cand_lf   = $signed({2'b00, lf_v}) - $signed({{(CAND_W-PEN_W){1'b0}}, pen_lf});

      mx = '0;
      if (cand_dg > mx) begin
         mx = cand_dg;
      end
      if (cand_lf > mx) begin
         mx = cand_lf;
      end
      if (cand_up > mx) begin
         mx = cand_up;
      end

      if (mx == '0) begin
         dir = DIR_NONE;
      end else if (mx == cand_dg) begin
         dir = DIR_DIAG;
      end else if (mx == cand_lf) begin
         dir = DIR_LEFT;
      end else begin
         dir = DIR_UP;
      end

      if (mx > $signed({2'b00, VALUE_MAX})) begin
         val = VALUE_MAX;
      end else begin
         val = mx[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         s2_ff <= cell_in;
      end
      if (ctrl.advance) begin
         s3_ff.value <= val;
         s3_ff.dir   <= dir;
         s3_ff.row   <= s2_ff.row;
         s3_ff.col   <= s2_ff.col;
         s3_ff.done  <= s2_ff.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_value_ff <= '0;
         left_dir_ff   <= DIR_NONE;
         diag_value_ff <= '0;
      end else if (ctrl.advance) begin
         left_value_ff <= val;
         left_dir_ff   <= dir;
         diag_value_ff <= up_v;
      end
   end

   assign wr_addr       = s2_ff.col;
   assign wr_data.dir   = dir;
   assign wr_data.value = val;
   assign cell_out      = s3_ff;

endmodule

@@ sv/lacs_best_track.sv @@
// output register and running best cell of the matrix
module lacs_best_track (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  lacs_pkg::cell_out_type cell_data,
   output lacs_pkg::result_type   result
);
   import lacs_pkg::*;

   logic               best_valid_ff;
   logic [VALUE_W-1:0] best_value_ff;
   logic [ROW_W-1:0]   best_row_ff;
   logic [COL_W-1:0]   best_col_ff;
   result_type         result_ff;

   logic               update;
   logic [VALUE_W-1:0] cur_value;
   logic [ROW_W-1:0]   cur_row;
   logic [COL_W-1:0]   cur_col;
   result_type         result_in;

   always_comb begin
      update    = !best_valid_ff || (cell_data.value > best_value_ff);
      cur_value = update ? cell_data.value : best_value_ff;
      cur_row   = update ? cell_data.row : best_row_ff;
      cur_col   = update ? cell_data.col : best_col_ff;

      result_in.cell_value  = cell_data.value;
      result_in.direction   = cell_data.dir;
      result_in.best_value  = cur_value;
      result_in.best_row    = {1'b0, cur_row} + 1'b1;
      result_in.best_col    = {1'b0, cur_col} + 1'b1;
      result_in.matrix_done = cell_data.done;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
         best_value_ff <= '0;
         best_row_ff   <= '0;
         best_col_ff   <= '0;
      end else if (load) begin
         if (cell_data.done) begin
            best_valid_ff <= 1'b0;
            best_value_ff <= '0;
            best_row_ff   <= '0;
            best_col_ff   <= '0;
         end else begin
            best_valid_ff <= 1'b1;
            best_value_ff <= cur_value;
            best_row_ff   <= cur_row;
            best_col_ff   <= cur_col;
         end
      end
   end

   assign result = result_ff;

endmodule

@@ sv/local_alignment_cell_scorer_top.sv @@
// top level of the local alignment cell scorer
//
// cells arrive on req_ch in row-major order over a num_rows by num_cols
// grid, one transaction per cell; each produces one transaction on rsp_ch
// with the cell value, its direction, the best cell so far and a flag on
// the last cell of the matrix. csr_we writes num_rows, num_cols or weighted
// at csr_index; write only while no cell is in flight.
// four register stages: weighting multiply, row store read, cell maximum,
// best tracking into the output register. one cell per cycle is sustained
// while rsp_ch is ready and the row store is not sweeping; the row store's
// read-modify-write keeps up because same-column back-to-back accesses
// are forwarded inside the store.
// after reset the row store sweeps every entry to zero with req_ch
// ready held low; csr writes are taken meanwhile. a stalled rsp_ch holds
// its result and the stages behind it keep filling until all are occupied.
module local_alignment_cell_scorer_top (
   input  logic                           clock,
   input  logic                           reset,
   lacs_req_if.sink                       req_ch,
   lacs_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [lacs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lacs_pkg::SIZE_W-1:0]    csr_wdata
);
   import lacs_pkg::*;

   logic [SIZE_W-1:0] num_rows_ff;
   logic [SIZE_W-1:0] num_cols_ff;
   logic              weighted_ff;
   logic [ROW_W-1:0]  row_cnt_ff;
   logic [ROW_W-1:0]  row_cnt_in;
   logic [COL_W-1:0]  col_cnt_ff;
   logic [COL_W-1:0]  col_cnt_in;
   logic              v1_ff, v2_ff, v3_ff, vo_ff;
   cell_in_type       s1_ff;
   cell_in_type       s1_in;

   logic [SIZE_W-1:0]         rows_eff;
   logic [SIZE_W-1:0]         cols_eff;
   logic                      last_col;
   logic                      done;
   logic [WT_W-1:0]           wt;
   logic signed [SCORE_W:0]   prod;
   logic                      en_out, en3, en2, en1;
   logic                      acc, mv12, mv23, mv3o;
   logic                      busy;
   stage_ctrl_type            calc_ctrl;
   entry_type                 up_entry;
   logic [COL_W-1:0]          wr_addr;
   entry_type                 wr_data;
   cell_out_type              cell_out;
   result_type                result;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= SIZE_W'(1);
         num_cols_ff <= SIZE_W'(1);
         weighted_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_ROWS: num_rows_ff <= csr_wdata;
            CSR_NUM_COLS: num_cols_ff <= csr_wdata;
            CSR_WEIGHTED: weighted_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stage enables, rippling back from the output register
   always_comb begin
      en_out = !vo_ff || rsp_ch.ready;
      en3    = !v3_ff || en_out;
      en2    = !v2_ff || en3;
      en1    = !v1_ff || en2;
      req_ch.ready = en1 && !busy;
      acc    = req_ch.valid && req_ch.ready;
      mv12   = v1_ff && en2;
      mv23   = v2_ff && en3;
      mv3o   = v3_ff && en_out;
      calc_ctrl.load    = mv12;
      calc_ctrl.advance = mv23;
   end

   always_comb begin
      if (num_rows_ff == '0) begin
         rows_eff = SIZE_W'(1);
      end else if (num_rows_ff > SIZE_W'(MAX_ROWS)) begin
         rows_eff = SIZE_W'(MAX_ROWS);
      end else begin
         rows_eff = num_rows_ff;
      end
      if (num_cols_ff == '0) begin
         cols_eff = SIZE_W'(1);
      end else if (num_cols_ff > SIZE_W'(MAX_COLS)) begin
         cols_eff = SIZE_W'(MAX_COLS);
      end else begin
         cols_eff = num_cols_ff;
      end

      last_col = (SIZE_W'(col_cnt_ff) + 1'b1) >= cols_eff;
      done     = last_col && ((SIZE_W'(row_cnt_ff) + 1'b1) >= rows_eff);

      row_cnt_in = row_cnt_ff;
      col_cnt_in = col_cnt_ff;
      if (acc) begin
         if (done) begin
            row_cnt_in = '0;
            col_cnt_in = '0;
         end else if (last_col) begin
            row_cnt_in = row_cnt_ff + 1'b1;
            col_cnt_in = '0;
         end else begin
            col_cnt_in = col_cnt_ff + 1'b1;
         end
      end

      wt   = (req_ch.row_weight < req_ch.col_weight) ? req_ch.row_weight : req_ch.col_weight;
      prod = req_ch.match_score * $signed({1'b0, wt});

      s1_in.score     = weighted_ff ? prod[SCORE_W-1:0] : SCORE_W'(req_ch.match_score);
      s1_in.open_p    = req_ch.open_penalty;
      s1_in.ext_p     = req_ch.ext_penalty;
      s1_in.row       = row_cnt_ff;
      s1_in.col       = col_cnt_ff;
      s1_in.first_row = (row_cnt_ff == '0);
      s1_in.first_col = (col_cnt_ff == '0);
      s1_in.done      = done;
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff <= '0;
         col_cnt_ff <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         vo_ff      <= 1'b0;
      end else begin
         row_cnt_ff <= row_cnt_in;
         col_cnt_ff <= col_cnt_in;
         if (acc) begin
            v1_ff <= 1'b1;
         end else if (mv12) begin
            v1_ff <= 1'b0;
         end
         if (mv12) begin
            v2_ff <= 1'b1;
         end else if (mv23) begin
            v2_ff <= 1'b0;
         end
         if (mv23) begin
            v3_ff <= 1'b1;
         end else if (mv3o) begin
            v3_ff <= 1'b0;
         end
         if (mv3o) begin
            vo_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            vo_ff <= 1'b0;
         end
      end
   end

   lacs_row_store u_row_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mv12),
      .rd_addr (s1_ff.col),
      .wr_en   (mv23),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (up_entry),
      .busy    (busy)
   );

   lacs_cell_calc u_cell_calc (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (calc_ctrl),
      .cell_in  (s1_ff),
      .up_entry (up_entry),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .cell_out (cell_out)
   );

   lacs_best_track u_best_track (
      .clock     (clock),
      .reset     (reset),
      .load      (mv3o),
      .cell_data (cell_out),
      .result    (result)
   );

   assign rsp_ch.valid       = vo_ff;
   assign rsp_ch.cell_value  = result.cell_value;
   assign rsp_ch.direction   = result.direction;
   assign rsp_ch.best_value  = result.best_value;
   assign rsp_ch.best_row    = result.best_row;
   assign rsp_ch.best_col    = result.best_col;
   assign rsp_ch.matrix_done = result.matrix_done;

endmodule

@@ test/lacs_cell_checker.sv @@
// cell result checker: predicts each scored cell and compares the result channel against it
module lacs_cell_checker (
   input  logic                           clock,
   input  logic                           reset,
   lacs_req_if                            req_ch,
   lacs_rsp_if                            rsp_ch,
   input  logic                           csr_we,
   input  logic [lacs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lacs_pkg::SIZE_W-1:0]    csr_wdata,
   output int                             pending,
   output int                             fail_count,
   output int                             checked_count,
   output int                             matrix_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import lacs_pkg::*;

   logic [VALUE_W-1:0] row_values [MAX_COLS];
   dir_type            row_dirs [MAX_COLS];
   logic [VALUE_W-1:0] left_value;
   logic [VALUE_W-1:0] diag_value;
   logic [VALUE_W-1:0] best_score;
   dir_type            left_dir;
   int unsigned        row_pos;
   int unsigned        col_pos;
   int unsigned        best_row_pos;
   int unsigned        best_col_pos;
   bit                 best_seen;
   logic [SIZE_W-1:0]  cfg_rows;
   logic [SIZE_W-1:0]  cfg_cols;
   logic               cfg_weighted;
   result_type         expected_cells [$];
   result_type         seen;
   result_type         want;

   function automatic int unsigned grid_size(input logic [SIZE_W-1:0] v,
                                             input int unsigned limit);
      if (v == 0) return 1;
      return (v > limit) ? limit : v;
   endfunction

   task automatic report_failure(input string msg);
      $display("[%0t] ERROR %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want_v);
      if (got !== want_v)
         report_failure($sformatf("result %0d: %s is %0d, predicted %0d",
                                  checked_count, name, got, want_v));
   endtask

   task automatic score_cell(input logic signed [SCORE_IN_W-1:0] score_in,
                             input logic [PEN_W-1:0] open_p,
                             input logic [PEN_W-1:0] ext_p,
                             input logic [WT_W-1:0] row_wt,
                             input logic [WT_W-1:0] col_wt,
                             output result_type res);
      int unsigned        rows;
      int unsigned        cols;
      int unsigned        r;
      int unsigned        c;
      longint             score;
      longint             up_v;
      longint             lf_v;
      longint             dg_v;
      longint             cand_dg;
      longint             cand_up;
      longint             cand_lf;
      longint             peak;
      dir_type            up_d;
      dir_type            lf_d;
      dir_type            dir;
      bit                 border;
      bit                 last_col;
      bit                 done;
      logic [VALUE_W-1:0] value;

      rows = grid_size(cfg_rows, MAX_ROWS);
      cols = grid_size(cfg_cols, MAX_COLS);
      r = row_pos;
      c = (col_pos >= MAX_COLS) ? 0 : col_pos;

      score = longint'(score_in);
      if (cfg_weighted)
         score = score * longint'((row_wt < col_wt) ? row_wt : col_wt);

      // outside the grid reads as zero with no direction
      border = (r == 0) || (c == 0);
      up_v = 0;
      up_d = DIR_NONE;
      lf_v = 0;
      lf_d = DIR_NONE;
      dg_v = 0;
      if (r != 0) begin
         up_v = longint'(row_values[c]);
         up_d = row_dirs[c];
      end
      if (c != 0) begin
         lf_v = longint'(left_value);
         lf_d = left_dir;
         dg_v = longint'(diag_value);
      end

      cand_dg = dg_v + score;
      cand_up = up_v - longint'((!border && up_d == DIR_UP) ? ext_p : open_p);
      cand_lf = lf_v - longint'((!border && lf_d == DIR_LEFT) ? ext_p : open_p);

      peak = 0;
      if (cand_dg > peak) peak = cand_dg;
      if (cand_lf > peak) peak = cand_lf;
      if (cand_up > peak) peak = cand_up;

      if (peak == 0) dir = DIR_NONE;
      else if (peak == cand_dg) dir = DIR_DIAG;
      else if (peak == cand_lf) dir = DIR_LEFT;
      else dir = DIR_UP;

      value = (peak > longint'(VALUE_MAX)) ? VALUE_MAX : VALUE_W'(peak);

      // old upper value becomes the next cell's diagonal
      diag_value = VALUE_W'(up_v);
      row_values[c] = value;
      row_dirs[c] = dir;
      left_value = value;
      left_dir = dir;

      if (!best_seen || value > best_score) begin
         best_seen = 1'b1;
         best_score = value;
         best_row_pos = r;
         best_col_pos = c;
      end

      last_col = (c + 1 >= cols);
      done = last_col && (r + 1 >= rows);

      res.cell_value = value;
      res.direction = dir;
      res.best_value = best_score;
      res.best_row = SIZE_W'(best_row_pos + 1);
      res.best_col = SIZE_W'(best_col_pos + 1);
      res.matrix_done = done;

      if (done) begin
         row_pos = 0;
         col_pos = 0;
         best_seen = 1'b0;
         best_score = '0;
         best_row_pos = 0;
         best_col_pos = 0;
      end else if (last_col) begin
         col_pos = 0;
         row_pos = r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (row_values[i]) begin
            row_values[i] = '0;
            row_dirs[i] = DIR_NONE;
         end
         left_value = '0;
         left_dir = DIR_NONE;
         diag_value = '0;
         row_pos = 0;
         col_pos = 0;
         best_seen = 1'b0;
         best_score = '0;
         best_row_pos = 0;
         best_col_pos = 0;
         cfg_rows = SIZE_W'(1);
         cfg_cols = SIZE_W'(1);
         cfg_weighted = 1'b0;
         expected_cells.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.cell_value = rsp_ch.cell_value;
            seen.direction = rsp_ch.direction;
            seen.best_value = rsp_ch.best_value;
            seen.best_row = rsp_ch.best_row;
            seen.best_col = rsp_ch.best_col;
            seen.matrix_done = rsp_ch.matrix_done;
            checked_count++;
            if (seen.matrix_done === 1'b1) matrix_count++;
            if (expected_cells.size() == 0) begin
               report_failure($sformatf("result %0d arrived with no cell waiting, value %0d",
                                        checked_count, seen.cell_value));
            end else begin
               want = expected_cells.pop_front();
               check_field("cell_value", seen.cell_value, want.cell_value);
               check_field("direction", seen.direction, want.direction);
               check_field("best_value", seen.best_value, want.best_value);
               check_field("best_row", seen.best_row, want.best_row);
               check_field("best_col", seen.best_col, want.best_col);
               check_field("matrix_done", seen.matrix_done, want.matrix_done);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            score_cell(req_ch.match_score, req_ch.open_penalty, req_ch.ext_penalty,
                       req_ch.row_weight, req_ch.col_weight, want);
            expected_cells.push_back(want);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_NUM_ROWS: cfg_rows = csr_wdata;
               CSR_NUM_COLS: cfg_cols = csr_wdata;
               CSR_WEIGHTED: cfg_weighted = csr_wdata[0];
               default: ;
            endcase
         end
      end
      pending <= expected_cells.size();
   end

endmodule

@@ test/tb.sv @@
// testbench top for the local alignment cell scorer: stimulus, idling phases and verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lacs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int CELL_TARGET = 1800;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_wdata;
   int                   gap_pct;
   int                   stall_pct;
   int                   cycles;
   int                   sent;
   int                   configs;
   int                   segments;
   int                   pending;
   int                   fail_count;
   int                   checked_count;
   int                   matrix_count;

   lacs_req_if req_ch ();
   lacs_rsp_if rsp_ch ();

   local_alignment_cell_scorer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lacs_cell_checker cell_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .pending       (pending),
      .fail_count    (fail_count),
      .checked_count (checked_count),
      .matrix_count  (matrix_count)
   );

   always #1ns clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("local_alignment_cell_scorer_top test failed");
         $finish;
      end
   end

   function automatic logic [PEN_W-1:0] pick_penalty();
      case ($urandom_range(7))
         0: return PEN_W'($urandom);
         1: return '0;
         2: return '1;
         default: return PEN_W'(8 * $urandom_range(4));
      endcase
   endfunction

   function automatic logic [WT_W-1:0] pick_weight();
      case ($urandom_range(3))
         0: return WT_W'($urandom);
         1: return WT_W'(255 * $urandom_range(1));
         default: return WT_W'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(15))
         0: return '0;
         1: return SIZE_W'($urandom_range(1024, 2047));
         2: return SIZE_W'(1);
         default: return SIZE_W'($urandom_range(2, 6));
      endcase
   endfunction

   task automatic set_idling(input int phase);
      case (phase % 4)
         0: begin
            gap_pct = 0;
            stall_pct <= 0;
         end
         1: begin
            gap_pct = 45;
            stall_pct <= 0;
         end
         2: begin
            gap_pct = 0;
            stall_pct <= 45;
         end
         default: begin
            gap_pct = 9;
            stall_pct <= 9;
         end
      endcase
   endtask

   task automatic send_cell(input logic signed [SCORE_IN_W-1:0] score,
                            input logic [PEN_W-1:0] open_p,
                            input logic [PEN_W-1:0] ext_p,
                            input logic [WT_W-1:0] row_wt,
                            input logic [WT_W-1:0] col_wt);
      while ($urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.match_score <= score;
      req_ch.open_penalty <= open_p;
      req_ch.ext_penalty <= ext_p;
      req_ch.row_weight <= row_wt;
      req_ch.col_weight <= col_wt;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_random_cell();
      logic signed [SCORE_IN_W-1:0] score;
      case ($urandom_range(9))
         0: score = SCORE_IN_W'($urandom);
         1: begin
            if ($urandom_range(1)) score = 16'sh7fff;
            else score = 16'sh8000;
         end
         default: score = SCORE_IN_W'(16 * int'($urandom_range(8)) - 48);
      endcase
      send_cell(score, pick_penalty(), pick_penalty(), pick_weight(), pick_weight());
   endtask

   task automatic load_config(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols,
                              input logic weighted);
      csr_we <= 1'b1;
      csr_index <= CSR_NUM_ROWS;
      csr_wdata <= rows;
      @(posedge clock);
      csr_index <= CSR_NUM_COLS;
      csr_wdata <= cols;
      @(posedge clock);
      csr_index <= CSR_WEIGHTED;
      csr_wdata <= SIZE_W'(weighted);
      @(posedge clock);
      csr_we <= 1'b0;
      configs++;
   endtask

   // every cell gives a result, so an empty expectation queue means idle
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_NUM_ROWS;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.match_score = '0;
      req_ch.open_penalty = '0;
      req_ch.ext_penalty = '0;
      req_ch.row_weight = '0;
      req_ch.col_weight = '0;
      gap_pct = 0;
      stall_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // single-cell matrices at reset sizes: largest score, then a zero cell
      send_cell(16'sh7fff, 15'h7fff, 15'h0000, 8'h00, 8'h00);
      send_cell(16'sh8000, 15'h0000, 15'h7fff, 8'hff, 8'hff);
      wait_idle();

      // weighted 3 by 3 that saturates on the corner cell
      load_config(11'd3, 11'd3, 1'b1);
      send_cell(16'sh7fff, 15'h0000, 15'h0000, 8'hff, 8'hff);
      send_cell(16'sh7fff, 15'h0000, 15'h0000, 8'hff, 8'h00);
      send_cell(16'sh8000, 15'h0010, 15'h0004, 8'hff, 8'h80);
      send_cell(16'sh7fff, 15'h0000, 15'h0000, 8'hff, 8'hff);
      send_cell(16'sh7fff, 15'h0000, 15'h0000, 8'hff, 8'hff);
      send_cell(16'sh0000, 15'h7fff, 15'h0000, 8'h01, 8'h01);
      send_cell(16'sh0000, 15'h0000, 15'h0000, 8'h00, 8'h00);
      send_cell(16'sh0000, 15'h0000, 15'h0000, 8'h00, 8'h00);
      send_cell(16'sh7fff, 15'h0000, 15'h0000, 8'hff, 8'hff);
      wait_idle();

      // zero sizes act as one
      load_config(11'd0, 11'd0, 1'b0);
      send_cell(16'sh0010, 15'h0000, 15'h0000, 8'h55, 8'haa);
      wait_idle();

      // gaps opening along the first row, then from above; on these edge cells only the open penalty applies
      load_config(11'd2, 11'd4, 1'b0);
      send_cell(16'sh0100, 15'h0020, 15'h0008, 8'h00, 8'h00);
      send_cell(-16'sh0010, 15'h0020, 15'h0008, 8'h00, 8'h00);
      send_cell(-16'sh0010, 15'h0020, 15'h0008, 8'h00, 8'h00);
      send_cell(-16'sh0010, 15'h0020, 15'h0008, 8'h00, 8'h00);
      send_cell(-16'sh0010, 15'h0020, 15'h0008, 8'h00, 8'h00);
      send_cell(-16'sh0010, 15'h0020, 15'h0008, 8'h00, 8'h00);
      send_cell(16'sh0000, 15'h0000, 15'h0000, 8'h00, 8'h00);
      send_cell(16'sh0010, 15'h0000, 15'h0000, 8'h00, 8'h00);
      wait_idle();

      // oversized registers clamp to the maximum: one full row and a little more
      set_idling(3);
      load_config(11'd2047, 11'd2047, 1'b1);
      repeat (1030) send_random_cell();

      while (sent < CELL_TARGET) begin
         wait_idle();
         set_idling(segments);
         load_config(pick_size(), pick_size(), 1'($urandom_range(1)));
         repeat ($urandom_range(1, 48)) send_random_cell();
         segments++;
      end
      wait_idle();
      repeat (16) @(posedge clock);

      $display("%0d cells driven: a directed opening, a full 1024-column row, %0d random segments",
               sent, segments);
      $display("%0d results checked, %0d matrices completed, %0d register settings",
               checked_count, matrix_count, configs);
      if (fail_count == 0) begin
         $display("local_alignment_cell_scorer_top test passed");
      end else begin
         $display("local_alignment_cell_scorer_top test failed");
      end
      $finish;
   end

endmodule
